[hw/rtl/lcrm_pkg.sv]
// shared types and constants for the longest common run matcher
// no dependencies; used by the interfaces, the cells, the output buffer and the top level

package lcrm_pkg;

    localparam int NOTE_W      = 7;
    localparam int FIELD_ERR_W = 16;
    localparam int CNT_W       = 5;
    localparam int CFG_DATA_W  = 56;
    localparam int CFG_INDEX_W = 2;
    localparam int NOTES_PER_REG = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_LO = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PATTERN_HI = 2'd1;

    typedef logic [NOTE_W-1:0]      note_t;
    typedef logic [FIELD_ERR_W-1:0] field_err_t;
    typedef logic [CNT_W-1:0]       cnt_t;

    // per-cycle control handed to every cell of the row
    typedef struct packed {
        logic step;   // an item is taken this cycle
        logic flush;  // the item closes the sequence
    } cell_ctrl_t;

endpackage

[hw/rtl/lcrm_channels.sv]
// item channels of the longest common run matcher
// depends on lcrm_pkg

interface lcrm_note_if;
    logic                      valid;
    logic                      ready;
    lcrm_pkg::note_t           note_code;
    logic signed [lcrm_pkg::FIELD_ERR_W-1:0] note_error;
    logic                      seq_last;

    modport source (output valid, note_code, note_error, seq_last, input ready);
    modport sink   (input valid, note_code, note_error, seq_last, output ready);
endinterface

interface lcrm_run_if;
    logic                      valid;
    logic                      ready;
    lcrm_pkg::note_t           match_note;
    logic signed [lcrm_pkg::FIELD_ERR_W-1:0] match_error;
    lcrm_pkg::cnt_t            run_length;
    logic                      burst_end;

    modport source (output valid, match_note, match_error, run_length, burst_end, input ready);
    modport sink   (input valid, match_note, match_error, run_length, burst_end, output ready);
endinterface

[hw/rtl/lcrm_cell.sv]
// one cell of the dp row: run length for one pattern entry plus one history slot
// depends on lcrm_pkg

module lcrm_cell #(
    parameter int ERR_W = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  lcrm_pkg::cell_ctrl_t ctrl,
    input  lcrm_pkg::note_t      code,
    input  lcrm_pkg::note_t      pattern_code,
    input  lcrm_pkg::cnt_t       diag_count,
    input  lcrm_pkg::cnt_t       target,
    input  lcrm_pkg::note_t      hist_note_in,
    input  logic [ERR_W-1:0]     hist_err_in,
    output lcrm_pkg::cnt_t       count,
    output lcrm_pkg::note_t      hist_note,
    output logic [ERR_W-1:0]     hist_err,
    output logic                 hit
);

    lcrm_pkg::cnt_t   count_reg;
    lcrm_pkg::cnt_t   count_next;
    lcrm_pkg::note_t  hist_note_reg;
    logic [ERR_W-1:0] hist_err_reg;

    // diagonal neighbour holds the run ending one element back
    always_comb
    begin
        if (code == pattern_code)
        begin
            count_next = diag_count + lcrm_pkg::cnt_t'(1);
        end
        else
        begin
            count_next = '0;
        end
    end

    assign hit = ctrl.step && (count_next == target);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctrl.step)
        begin
            count_reg <= ctrl.flush ? '0 : count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.step)
        begin
            hist_note_reg <= hist_note_in;
            hist_err_reg  <= hist_err_in;
        end
    end

    assign count     = count_reg;
    assign hist_note = hist_note_reg;
    assign hist_err  = hist_err_reg;

endmodule

[hw/rtl/lcrm_out_buf.sv]
// burst buffer: holds a copy of the best run and drains it one item a cycle while pop is high
// depends on lcrm_pkg

module lcrm_out_buf #(
    parameter int DEPTH = 10
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   load,
    input  lcrm_pkg::cnt_t         len,
    input  lcrm_pkg::note_t        notes [DEPTH],
    input  lcrm_pkg::field_err_t   errs  [DEPTH],
    input  logic                   pop,
    output logic                   valid,
    output lcrm_pkg::note_t        note,
    output lcrm_pkg::field_err_t   err,
    output lcrm_pkg::cnt_t         run_len,
    output logic                   last
);

    lcrm_pkg::note_t      note_reg [DEPTH];
    lcrm_pkg::field_err_t err_reg  [DEPTH];
    lcrm_pkg::cnt_t       len_reg;
    lcrm_pkg::cnt_t       rem_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg <= '0;
        end
        else if (load)
        begin
            // an empty run still yields one item
            rem_reg <= (len == '0) ? lcrm_pkg::cnt_t'(1) : len;
        end
        else if (pop)
        begin
            rem_reg <= rem_reg - lcrm_pkg::cnt_t'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            len_reg <= len;
            for (int k = 0; k < DEPTH; k++)
            begin
                if ((k == 0) && (len == '0))
                begin
                    note_reg[k] <= '0;
                    err_reg[k]  <= '0;
                end
                else
                begin
                    note_reg[k] <= notes[k];
                    err_reg[k]  <= errs[k];
                end
            end
        end
        else if (pop)
        begin
            for (int k = 0; k < DEPTH - 1; k++)
            begin
                note_reg[k] <= note_reg[k+1];
                err_reg[k]  <= err_reg[k+1];
            end
        end
    end

    assign valid   = (rem_reg != '0);
    assign note    = note_reg[0];
    assign err     = err_reg[0];
    assign run_len = len_reg;
    assign last    = (rem_reg == lcrm_pkg::cnt_t'(1));

endmodule

[hw/rtl/longest_common_run_matcher_top.sv]
// top level of the longest common run matcher: pattern registers, cell row,
// best-run store and burst buffer; depends on lcrm_pkg, lcrm_channels, lcrm_cell, lcrm_out_buf
//
//  channel   dir  handshake         payload
//  notes     in   valid / ready     note_code, note_error, seq_last
//  runs      out  valid / ready     match_note, match_error, run_length, burst_end
//  cfg       in   cfg_we            cfg_index, cfg_data (no read-back)
//
// one item a cycle unless a closing item waits; the whole row of cells updates in that cycle
// a closing item copies the best run to the burst buffer; it gives one result per ready cycle
// a closing item waits while the buffer still drains
// reset clears run lengths, best length and the buffer at once; no clearing pass
// stalls on the run side hold the buffer and block only closing items

module longest_common_run_matcher_top #(
    parameter int PATTERN_LEN = 10,
    parameter int ERROR_BITS  = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    lcrm_note_if.sink                               notes,
    lcrm_run_if.source                              runs,
    input  logic                                    cfg_we,
    input  logic [lcrm_pkg::CFG_INDEX_W-1:0]        cfg_index,
    input  logic [lcrm_pkg::CFG_DATA_W-1:0]         cfg_data
);

    logic [lcrm_pkg::CFG_DATA_W-1:0] pattern_lo_reg;
    logic [lcrm_pkg::CFG_DATA_W-1:0] pattern_hi_reg;

    lcrm_pkg::cell_ctrl_t ctrl;
    logic                 accept;
    logic                 buf_valid;

    logic [ERROR_BITS-1:0] err_in;
    lcrm_pkg::note_t       pat_code   [PATTERN_LEN];
    lcrm_pkg::cnt_t        cnt        [PATTERN_LEN];
    lcrm_pkg::cnt_t        diag       [PATTERN_LEN];
    lcrm_pkg::note_t       note_chain [PATTERN_LEN];
    logic [ERROR_BITS-1:0] err_chain  [PATTERN_LEN];
    logic [PATTERN_LEN-1:0] hit;
    logic                  hit_any;

    lcrm_pkg::cnt_t        best_reg;
    lcrm_pkg::cnt_t        best_next;
    lcrm_pkg::cnt_t        target;
    lcrm_pkg::note_t       best_note_reg  [PATTERN_LEN];
    logic [ERROR_BITS-1:0] best_err_reg   [PATTERN_LEN];
    lcrm_pkg::note_t       best_note_next [PATTERN_LEN];
    logic [ERROR_BITS-1:0] best_err_next  [PATTERN_LEN];
    lcrm_pkg::field_err_t  best_err_field [PATTERN_LEN];

    lcrm_pkg::note_t       buf_note;
    lcrm_pkg::field_err_t  buf_err;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_lo_reg <= '0;
            pattern_hi_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                lcrm_pkg::REG_PATTERN_LO: pattern_lo_reg <= cfg_data;
                lcrm_pkg::REG_PATTERN_HI: pattern_hi_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a closing item needs the burst buffer empty
    assign notes.ready = !buf_valid || !notes.seq_last;
    assign accept      = notes.valid && notes.ready;
    assign ctrl.step   = accept;
    assign ctrl.flush  = notes.seq_last;

    generate
        if (ERROR_BITS >= lcrm_pkg::FIELD_ERR_W)
        begin : g_err_wide
            assign err_in = ERROR_BITS'(notes.note_error);
        end
        else
        begin : g_err_narrow
            assign err_in = notes.note_error[ERROR_BITS-1:0];
        end
    endgenerate

    assign note_chain[0] = notes.note_code;
    assign err_chain[0]  = err_in;
    assign diag[0]       = '0;
    assign target        = best_reg + lcrm_pkg::cnt_t'(1);

    genvar j;
    generate
        for (j = 0; j < PATTERN_LEN; j++)
        begin : g_cell
            if (j < lcrm_pkg::NOTES_PER_REG)
            begin : g_lo
                assign pat_code[j] = pattern_lo_reg[j*lcrm_pkg::NOTE_W +: lcrm_pkg::NOTE_W];
            end
            else
            begin : g_hi
                assign pat_code[j] =
                    pattern_hi_reg[(j-lcrm_pkg::NOTES_PER_REG)*lcrm_pkg::NOTE_W
                                   +: lcrm_pkg::NOTE_W];
            end

            if (j > 0)
            begin : g_diag
                assign diag[j] = cnt[j-1];
            end

            if (j < PATTERN_LEN - 1)
            begin : g_link
                lcrm_cell #(
                    .ERR_W (ERROR_BITS)
                ) u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctrl         (ctrl),
                    .code         (notes.note_code),
                    .pattern_code (pat_code[j]),
                    .diag_count   (diag[j]),
                    .target       (target),
                    .hist_note_in (note_chain[j]),
                    .hist_err_in  (err_chain[j]),
                    .count        (cnt[j]),
                    .hist_note    (note_chain[j+1]),
                    .hist_err     (err_chain[j+1]),
                    .hit          (hit[j])
                );
            end
            else
            begin : g_end
                // oldest slot drops out of the history
                lcrm_cell #(
                    .ERR_W (ERROR_BITS)
                ) u_cell (
                    .clk          (clk),
                    .rst_n        (rst_n),
                    .ctrl         (ctrl),
                    .code         (notes.note_code),
                    .pattern_code (pat_code[j]),
                    .diag_count   (diag[j]),
                    .target       (target),
                    .hist_note_in (note_chain[j]),
                    .hist_err_in  (err_chain[j]),
                    .count        (cnt[j]),
                    .hist_note    (),
                    .hist_err     (),
                    .hit          (hit[j])
                );
            end
        end
    endgenerate

    // runs grow by one per item, so a new best is always exactly one longer
    assign hit_any   = |hit;
    assign best_next = hit_any ? target : best_reg;

    // new best run is the newest best+1 elements, copied oldest first
    always_comb
    begin
        for (int k = 0; k < PATTERN_LEN; k++)
        begin
            best_note_next[k] = best_note_reg[k];
            best_err_next[k]  = best_err_reg[k];
            if (hit_any && (lcrm_pkg::cnt_t'(k) <= best_reg))
            begin
                for (int i = 0; i < PATTERN_LEN; i++)
                begin
                    if (lcrm_pkg::cnt_t'(i) == best_reg - lcrm_pkg::cnt_t'(k))
                    begin
                        best_note_next[k] = note_chain[i];
                        best_err_next[k]  = err_chain[i];
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_reg <= '0;
        end
        else if (accept)
        begin
            best_reg <= notes.seq_last ? '0 : best_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && hit_any)
        begin
            for (int k = 0; k < PATTERN_LEN; k++)
            begin
                best_note_reg[k] <= best_note_next[k];
                best_err_reg[k]  <= best_err_next[k];
            end
        end
    end

    genvar k;
    generate
        for (k = 0; k < PATTERN_LEN; k++)
        begin : g_field
            if (ERROR_BITS >= lcrm_pkg::FIELD_ERR_W)
            begin : g_trunc
                assign best_err_field[k] = best_err_next[k][lcrm_pkg::FIELD_ERR_W-1:0];
            end
            else
            begin : g_ext
                assign best_err_field[k] = lcrm_pkg::FIELD_ERR_W'(best_err_next[k]);
            end
        end
    endgenerate

    lcrm_out_buf #(
        .DEPTH (PATTERN_LEN)
    ) u_out_buf (
        .clk     (clk),
        .rst_n   (rst_n),
        .load    (accept && notes.seq_last),
        .len     (best_next),
        .notes   (best_note_next),
        .errs    (best_err_field),
        .pop     (runs.valid && runs.ready),
        .valid   (buf_valid),
        .note    (buf_note),
        .err     (buf_err),
        .run_len (runs.run_length),
        .last    (runs.burst_end)
    );

    assign runs.valid       = buf_valid;
    assign runs.match_note  = buf_note;
    assign runs.match_error = buf_err;

endmodule

[bench/tb_top.sv]
// testbench for the longest common run matcher: note items in, run bursts out
// depends on lcrm_pkg, lcrm_channels and longest_common_run_matcher_top
`timescale 1ns / 100ps

module tb_top;

    localparam int PATTERN_LEN = 10;
    localparam int ERROR_BITS  = 16;
    localparam int HOLD_CYCLES = 150;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = PATTERN_LEN + 10;
    localparam int PHASE_ITEMS = 22;
    localparam logic [lcrm_pkg::CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [lcrm_pkg::CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;
    localparam lcrm_pkg::note_t NO_NOTE = 7'd108;

    typedef struct packed {
        lcrm_pkg::note_t      note;
        lcrm_pkg::field_err_t err;
        lcrm_pkg::cnt_t       len;
        logic                 last;
    } run_item_t;

    class run_scoreboard #(int ROW = 10);
        logic [lcrm_pkg::CFG_DATA_W-1:0] pat_lo;
        logic [lcrm_pkg::CFG_DATA_W-1:0] pat_hi;
        lcrm_pkg::cnt_t       row_len[ROW];
        lcrm_pkg::cnt_t       best_len;
        lcrm_pkg::note_t      hist_note[ROW];
        lcrm_pkg::field_err_t hist_err[ROW];
        lcrm_pkg::note_t      best_note[ROW];
        lcrm_pkg::field_err_t best_err[ROW];
        run_item_t  expected_runs[$];
        int         failures;
        int         reported;

        function new();
            pat_lo   = '0;
            pat_hi   = '0;
            best_len = '0;
            failures = 0;
            reported = 0;
            foreach (row_len[j]) row_len[j] = '0;
        endfunction

        function void write_reg(logic [lcrm_pkg::CFG_INDEX_W-1:0] idx,
                                logic [lcrm_pkg::CFG_DATA_W-1:0] data);
            if (idx == lcrm_pkg::REG_PATTERN_LO)
                pat_lo = data;
            else if (idx == lcrm_pkg::REG_PATTERN_HI)
                pat_hi = data;
        endfunction

        function lcrm_pkg::note_t pattern_note(int j);
            if (j < lcrm_pkg::NOTES_PER_REG)
                return pat_lo[lcrm_pkg::NOTE_W*j +: lcrm_pkg::NOTE_W];
            return pat_hi[lcrm_pkg::NOTE_W*(j-lcrm_pkg::NOTES_PER_REG) +: lcrm_pkg::NOTE_W];
        endfunction

        function int pending();
            return expected_runs.size();
        endfunction

        // row update, best-run capture and, on a closing item, the burst it yields
        function void note_item(lcrm_pkg::note_t code, lcrm_pkg::field_err_t err, logic last);
            int row_max;
            int v;
            run_item_t r;
            row_max = 0;
            for (int k = ROW - 1; k > 0; k--)
            begin
                hist_note[k] = hist_note[k-1];
                hist_err[k]  = hist_err[k-1];
            end
            hist_note[0] = code;
            hist_err[0]  = err;
            // top entry first so the diagonal still holds the previous element
            for (int j = ROW - 1; j >= 0; j--)
            begin
                v = 0;
                if (code == pattern_note(j))
                begin
                    v = ((j == 0) ? 0 : int'(row_len[j-1])) + 1;
                    if (v > 31)
                        v = 31;
                end
                row_len[j] = lcrm_pkg::cnt_t'(v);
                if (v > row_max)
                    row_max = v;
            end
            if (row_max > best_len && row_max <= ROW)
            begin
                best_len = lcrm_pkg::cnt_t'(row_max);
                for (int k = 0; k < row_max; k++)
                begin
                    best_note[k] = hist_note[row_max-1-k];
                    best_err[k]  = hist_err[row_max-1-k];
                end
            end
            if (!last)
                return;
            if (best_len == 0)
            begin
                r = '{note: '0, err: '0, len: '0, last: 1'b1};
                expected_runs.push_back(r);
            end
            else
            begin
                for (int k = 0; k < best_len; k++)
                begin
                    r.note = best_note[k];
                    r.err  = best_err[k];
                    r.len  = best_len;
                    r.last = (k + 1 == best_len);
                    expected_runs.push_back(r);
                end
            end
            foreach (row_len[j]) row_len[j] = '0;
            best_len = '0;
        endfunction

        function void check_run(run_item_t got);
            run_item_t want;
            if (expected_runs.size() == 0)
            begin
                failures++;
                if (reported < 10)
                begin
                    reported++;
                    $display("unexpected run item: note %0d err %0d len %0d end %0b",
                             got.note, $signed(got.err), got.len, got.last);
                end
                return;
            end
            want = expected_runs.pop_front();
            if (got.note !== want.note || got.err !== want.err ||
                got.len !== want.len || got.last !== want.last)
            begin
                failures++;
                if (reported < 10)
                begin
                    reported++;
                    $display("run item mismatch: expected note %0d err %0d len %0d end %0b",
                             want.note, $signed(want.err), want.len, want.last);
                    $display("                   actual   note %0d err %0d len %0d end %0b",
                             got.note, $signed(got.err), got.len, got.last);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [lcrm_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [lcrm_pkg::CFG_DATA_W-1:0]  cfg_data;

    lcrm_note_if notes_ch ();
    lcrm_run_if  runs_ch ();

    longest_common_run_matcher_top #(
        .PATTERN_LEN (PATTERN_LEN),
        .ERROR_BITS  (ERROR_BITS)
    ) DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .notes     (notes_ch),
        .runs      (runs_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    run_scoreboard #(PATTERN_LEN) sb;

    logic send_idle;
    logic recv_idle;
    logic hold_req;
    logic moved;
    int   items_sent;

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // handshakes are sampled mid-cycle, where every signal has settled
    always @(negedge clk)
    begin
        run_item_t got;
        logic seen;
        seen = 1'b0;
        if (rst_n && notes_ch.valid && notes_ch.ready)
        begin
            sb.note_item(notes_ch.note_code, notes_ch.note_error, notes_ch.seq_last);
            seen = 1'b1;
        end
        if (rst_n && runs_ch.valid && runs_ch.ready)
        begin
            got.note = runs_ch.match_note;
            got.err  = runs_ch.match_error;
            got.len  = runs_ch.run_length;
            got.last = runs_ch.burst_end;
            sb.check_run(got);
            seen = 1'b1;
        end
        if (seen)
            moved <= 1'b1;
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            quiet = moved ? 0 : quiet + 1;
            moved <= 1'b0;
        end
        $display("TEST FAILED");
        $finish;
    end

    // run side: random stalls, plus one long hold-off on request
    initial
    begin
        int stall;
        logic took;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                runs_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                stall = recv_idle ? $urandom_range(0, 7) : 0;
                if (stall > 0)
                begin
                    runs_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
                runs_ch.ready <= 1'b1;
                do
                begin
                    @(negedge clk);
                    took = runs_ch.valid;
                    @(posedge clk);
                end while (!took);
            end
        end
    end

    task automatic send_note(input lcrm_pkg::note_t code, input lcrm_pkg::field_err_t err,
                             input logic last);
        int gap;
        logic took;
        gap = send_idle ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            notes_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        notes_ch.valid      <= 1'b1;
        notes_ch.note_code  <= code;
        notes_ch.note_error <= err;
        notes_ch.seq_last   <= last;
        do
        begin
            @(negedge clk);
            took = notes_ch.ready;
            @(posedge clk);
        end while (!took);
        items_sent++;
    endtask

    task automatic write_reg(input logic [lcrm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [lcrm_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, data);
        @(posedge clk);
    endtask

    // stop offering items, then let the last burst and any trailing work finish
    task automatic drain();
        notes_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    function automatic lcrm_pkg::note_t random_note();
        return ($urandom_range(0, 7) == 0) ? NO_NOTE
                                           : lcrm_pkg::note_t'($urandom_range(0, 127));
    endfunction

    function automatic lcrm_pkg::field_err_t random_error();
        case ($urandom_range(0, 7))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            default: return lcrm_pkg::field_err_t'($urandom);
        endcase
    endfunction

    // alphabet 0: any code, 1: four codes only, 2: no-note code mixed in
    function automatic logic [lcrm_pkg::CFG_DATA_W-1:0] random_pattern(input int alphabet);
        logic [lcrm_pkg::CFG_DATA_W-1:0] reg_val;
        for (int j = 0; j < lcrm_pkg::NOTES_PER_REG; j++)
        begin
            case (alphabet)
                1:
                    reg_val[lcrm_pkg::NOTE_W*j +: lcrm_pkg::NOTE_W] =
                        lcrm_pkg::note_t'($urandom_range(0, 3));
                2:
                    reg_val[lcrm_pkg::NOTE_W*j +: lcrm_pkg::NOTE_W] =
                        ($urandom_range(0, 2) == 0) ? NO_NOTE
                                                    : lcrm_pkg::note_t'($urandom_range(100, 115));
                default:
                    reg_val[lcrm_pkg::NOTE_W*j +: lcrm_pkg::NOTE_W] =
                        lcrm_pkg::note_t'($urandom_range(0, 127));
            endcase
        end
        return reg_val;
    endfunction

    // mostly slices of the pattern wrapped in noise, so long runs and ties occur
    task automatic send_random_sequence();
        lcrm_pkg::note_t codes[$];
        int mode;
        int start;
        int span;
        mode = $urandom_range(0, 9);
        if (mode <= 6)
        begin
            start = $urandom_range(0, PATTERN_LEN - 1);
            span  = $urandom_range(1, PATTERN_LEN - start);
            repeat ($urandom_range(0, 3)) codes.push_back(random_note());
            for (int k = 0; k < span; k++)
                codes.push_back(($urandom_range(0, 15) == 0) ? random_note()
                                                             : sb.pattern_note(start + k));
            repeat ($urandom_range(0, 2)) codes.push_back(random_note());
        end
        else if (mode <= 8)
        begin
            repeat ($urandom_range(1, 8)) codes.push_back(random_note());
        end
        else
        begin
            repeat ($urandom_range(1, 12))
                codes.push_back(sb.pattern_note($urandom_range(0, PATTERN_LEN - 1)));
        end
        foreach (codes[k])
            send_note(codes[k], random_error(), k == codes.size() - 1);
    endtask

    initial
    begin
        lcrm_pkg::note_t dir_pat[16];
        logic [lcrm_pkg::CFG_DATA_W-1:0] lo;
        logic [lcrm_pkg::CFG_DATA_W-1:0] hi;
        int phase_start;

        sb = new();
        send_idle  = 1'b0;
        recv_idle  = 1'b0;
        hold_req   = 1'b0;
        moved      = 1'b0;
        items_sent = 0;
        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        notes_ch.valid      = 1'b0;
        notes_ch.note_code  = '0;
        notes_ch.note_error = '0;
        notes_ch.seq_last   = 1'b0;
        runs_ch.ready       = 1'b0;

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // reset pattern is all code 0, so a run of zeros matches from entry 0
        send_note(7'd0, 16'h7FFF, 1'b0);
        send_note(7'd0, 16'h8000, 1'b0);
        send_note(7'd0, 16'h0001, 1'b1);
        drain();

        dir_pat = '{7'd60, 7'd61, 7'd62, 7'd63, 7'd64, NO_NOTE, 7'd127, 7'd0,
                    7'd65, 7'd66, 7'd67, 7'd85, 7'd85, 7'd85, 7'd85, 7'd85};
        for (int j = 0; j < lcrm_pkg::NOTES_PER_REG; j++)
        begin
            lo[lcrm_pkg::NOTE_W*j +: lcrm_pkg::NOTE_W] = dir_pat[j];
            hi[lcrm_pkg::NOTE_W*j +: lcrm_pkg::NOTE_W] = dir_pat[j + lcrm_pkg::NOTES_PER_REG];
        end
        write_reg(lcrm_pkg::REG_PATTERN_LO, lo);
        write_reg(lcrm_pkg::REG_PATTERN_HI, hi);

        // whole pattern: longest burst; the entry past the pattern length must not extend it
        send_note(7'd60, 16'h8000, 1'b0);
        send_note(7'd61, 16'h7FFF, 1'b0);
        send_note(7'd62, 16'hFFFF, 1'b0);
        send_note(7'd63, 16'h0000, 1'b0);
        send_note(7'd64, 16'h1234, 1'b0);
        send_note(NO_NOTE, 16'hA5A5, 1'b0);
        send_note(7'd127, 16'h5A5A, 1'b0);
        send_note(7'd0, 16'h0001, 1'b0);
        send_note(7'd65, 16'hFFFE, 1'b0);
        send_note(7'd66, 16'h4000, 1'b0);
        send_note(7'd67, 16'hC000, 1'b1);
        // nothing in common
        send_note(7'd1, 16'h0101, 1'b0);
        send_note(7'd2, 16'h0202, 1'b1);
        // two runs of equal length: the earlier one stays
        send_note(7'd61, 16'h1111, 1'b0);
        send_note(7'd62, 16'h2222, 1'b0);
        send_note(7'd5, 16'h3333, 1'b0);
        send_note(7'd63, 16'h4444, 1'b0);
        send_note(7'd64, 16'h5555, 1'b1);
        // closing item alone, the no-note code matching its pattern entry
        send_note(NO_NOTE, 16'h8001, 1'b1);
        drain();

        // writes beyond the two registers leave the pattern alone
        write_reg(REG_SPARE_A, '1);
        write_reg(REG_SPARE_B, '0);
        send_note(7'd60, 16'h0F0F, 1'b0);
        send_note(7'd61, 16'hF0F0, 1'b1);
        drain();

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0:
                begin
                    lo = '1;
                    hi = '1;
                end
                1:
                begin
                    lo = random_pattern(0);
                    hi = random_pattern(0);
                end
                2:
                begin
                    lo = random_pattern(1);
                    hi = random_pattern(1);
                end
                3:
                begin
                    lo = random_pattern(2);
                    hi = random_pattern(2);
                end
                4:
                begin
                    lo = '0;
                    hi = '0;
                end
                default:
                begin
                    lo = random_pattern(0);
                    hi = random_pattern(1);
                end
            endcase
            write_reg(lcrm_pkg::REG_PATTERN_LO, lo);
            write_reg(lcrm_pkg::REG_PATTERN_HI, hi);
            if (phase == 5)
                write_reg(REG_SPARE_A, random_pattern(0));
            send_idle = (phase != 0) && (phase != 2);
            recv_idle = (phase != 0);
            // long hold on the run side while items keep coming, so closing items back up
            if (phase == 2)
                hold_req = 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                send_random_sequence();
            drain();
        end

        if (sb.failures == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
